/* src/lpht_pkg.sv */
// Shared types and codes for the linear-probe hash table.
package lpht_pkg;

  localparam int KEY_CHARS_W = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int REG_VALUE_W = 16;
  localparam int FOUND_VAL_W = 16;
  localparam int SLOT_OUT_W  = 9;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // Normalized request: length saturated, bytes past the length zeroed.
  typedef struct packed {
    action_e                action;
    logic [KEY_CHARS_W-1:0] key_chars;
    logic [KEY_LEN_W-1:0]   key_len;
    logic [REG_VALUE_W-1:0] reg_value;
  } item_t;

  typedef struct packed {
    logic                   found;
    logic [FOUND_VAL_W-1:0] found_value;
    status_e                status;
    logic [SLOT_OUT_W-1:0]  slot_index;
  } res_t;

endpackage

/* src/lpht_front.sv */
// Front end: takes items, normalizes the key and computes the home slot.
module lpht_front #(
  parameter int SLOT_COUNT    = 347,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       hold_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lpht_pkg::action_e          in_action_i,
  input  logic [63:0]                in_key_chars_i,
  input  logic [3:0]                 in_key_len_i,
  input  logic [15:0]                in_reg_value_i,
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output lpht_pkg::item_t            q_item_o,
  output logic [$clog2(SLOT_COUNT)-1:0] q_home_o
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int ACC_W = IDX_W + 2;
  localparam logic [ACC_W-1:0] N_ACC   = ACC_W'(SLOT_COUNT);
  localparam logic [ACC_W-1:0] N2_ACC  = ACC_W'(2 * SLOT_COUNT);
  localparam logic [3:0]       LEN_MAX = 4'(MAX_KEY_BYTES);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  // Four bits of (r*16 + h*nib) mod N, MSB first; each step stays below 3N.
  function automatic logic [IDX_W-1:0] mulmod4(logic [IDX_W-1:0] r_in,
                                               logic [IDX_W-1:0] h,
                                               logic [3:0] nib);
    logic [ACC_W-1:0] r;
    logic [ACC_W-1:0] t;
    r = ACC_W'(r_in);
    for (int i = 3; i >= 0; i--) begin
      t = (r << 1) + (nib[i] ? ACC_W'(h) : '0);
      if (t >= N2_ACC) begin
        r = t - N2_ACC;
      end else if (t >= N_ACC) begin
        r = t - N_ACC;
      end else begin
        r = t;
      end
    end
    return r[IDX_W-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  lpht_pkg::item_t  item_q, item_d;
  logic [IDX_W-1:0] h_q, h_d;
  logic [IDX_W-1:0] r_q, r_d;
  logic [3:0]       byte_q, byte_d;
  logic             lo_q, lo_d;

  logic [3:0]       len_sat;
  logic [63:0]      key_m;
  logic [7:0]       cur_byte;
  logic [3:0]       nib;
  logic [IDX_W-1:0] r_new;
  logic             accept;

  assign in_ready_o = (state_q == F_IDLE) && !hold_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_valid_o  = (state_q == F_PUSH);
  assign q_item_o   = item_q;
  assign q_home_o   = h_q;

  always_comb begin
    len_sat = (in_key_len_i > LEN_MAX) ? LEN_MAX : in_key_len_i;
    for (int b = 0; b < 8; b++) begin
      key_m[b*8 +: 8] = (4'(b) < len_sat) ? in_key_chars_i[b*8 +: 8] : 8'h00;
    end
  end

  assign cur_byte = item_q.key_chars[{byte_q[2:0], 3'b000} +: 8];
  assign nib      = lo_q ? cur_byte[3:0] : cur_byte[7:4];
  assign r_new    = mulmod4(r_q, h_q, nib);

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    h_d     = h_q;
    r_d     = r_q;
    byte_d  = byte_q;
    lo_d    = lo_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_d.action    = in_action_i;
          item_d.key_chars = key_m;
          item_d.key_len   = len_sat;
          item_d.reg_value = in_reg_value_i;
          h_d    = IDX_W'(1);
          r_d    = '0;
          byte_d = '0;
          lo_d   = 1'b0;
          if (in_action_i == lpht_pkg::ACT_LOOKUP || in_action_i == lpht_pkg::ACT_INSERT) begin
            state_d = F_HASH;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_HASH: begin
        if (byte_q == item_q.key_len) begin
          state_d = F_PUSH;
        end else if (!lo_q) begin
          r_d  = r_new;
          lo_d = 1'b1;
        end else begin
          h_d    = r_new;
          r_d    = '0;
          lo_d   = 1'b0;
          byte_d = byte_q + 4'd1;
        end
      end
      F_PUSH: begin
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    h_q    <= h_d;
    r_q    <= r_d;
    byte_q <= byte_d;
    lo_q   <= lo_d;
  end

endmodule

/* src/lpht_queue.sv */
// Two-entry FIFO between front and back end.
module lpht_queue #(
  parameter int DATA_W = 95
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  logic [DATA_W-1:0] buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

/* src/lpht_back.sv */
// Back end: slot memory, probe walk, clear sweep and result register.
module lpht_back #(
  parameter int SLOT_COUNT    = 347,
  parameter int MAX_KEY_BYTES = 8,
  parameter int VALUE_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  lpht_pkg::item_t               q_item_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] q_home_i,
  output logic                          init_busy_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lpht_pkg::res_t                res_o
);

  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W     = 8 * MAX_KEY_BYTES;
  localparam int VAL_WIDE  = (VALUE_BITS > 16) ? VALUE_BITS : 16;
  localparam int SLOT_WIDE = (IDX_W > 9) ? IDX_W : 9;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT - 1);

  localparam logic [1:0] B_CLR   = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;
  localparam logic [1:0] B_RESP  = 2'd3;

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [3:0]            len;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] x);
    return (x == LAST_IDX) ? '0 : x + IDX_W'(1);
  endfunction

  function automatic logic [8:0] to_slot(logic [IDX_W-1:0] x);
    logic [SLOT_WIDE-1:0] w;
    w = SLOT_WIDE'(x);
    return w[8:0];
  endfunction

  entry_t mem [SLOT_COUNT];
  entry_t rd_q;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  logic [1:0]       state_q, state_d;
  lpht_pkg::item_t  cmd_q, cmd_d;
  logic [IDX_W-1:0] nxt_q, nxt_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             rd_ok_q, rd_ok_d;
  logic [CNT_W-1:0] vis_q, vis_d;
  logic             dup_q, dup_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             clr_resp_q, clr_resp_d;
  lpht_pkg::res_t   res_q, res_d;
  logic             out_valid_q, out_valid_d;
  lpht_pkg::res_t   out_q, out_d;

  logic                is_lookup;
  logic                match;
  logic                out_free;
  logic [VAL_WIDE-1:0] val_in_wide;
  logic [VAL_WIDE-1:0] val_out_wide;

  assign is_lookup    = (cmd_q.action == lpht_pkg::ACT_LOOKUP);
  assign match        = rd_q.valid && (rd_q.len == cmd_q.key_len) &&
                        (rd_q.key == cmd_q.key_chars[KEY_W-1:0]);
  assign out_free     = !out_valid_q || res_ready_i;
  assign val_in_wide  = VAL_WIDE'(cmd_q.reg_value);
  assign val_out_wide = VAL_WIDE'(rd_q.value);

  assign q_ready_o   = (state_q == B_IDLE);
  assign init_busy_o = (state_q == B_CLR) && !clr_resp_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    nxt_d       = nxt_q;
    cur_d       = cur_q;
    rd_ok_d     = rd_ok_q;
    vis_d       = vis_q;
    dup_d       = dup_q;
    clr_d       = clr_q;
    clr_resp_d  = clr_resp_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    wa          = cur_q;
    wd          = '0;

    unique case (state_q)
      B_CLR: begin
        we = 1'b1;
        wa = clr_q;
        clr_d = wrap_inc(clr_q);
        if (clr_q == LAST_IDX) begin
          state_d = clr_resp_q ? B_RESP : B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          cmd_d   = q_item_i;
          nxt_d   = q_home_i;
          rd_ok_d = 1'b0;
          vis_d   = '0;
          dup_d   = 1'b0;
          res_d   = '0;
          unique case (q_item_i.action)
            lpht_pkg::ACT_LOOKUP, lpht_pkg::ACT_INSERT: state_d = B_PROBE;
            lpht_pkg::ACT_CLEAR: begin
              clr_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = B_CLR;
            end
            default: state_d = B_RESP;
          endcase
        end
      end
      B_PROBE: begin
        // one read issued per cycle; data of cur_q is checked in the cycle after its read
        nxt_d   = wrap_inc(nxt_q);
        cur_d   = nxt_q;
        rd_ok_d = 1'b1;
        if (rd_ok_q) begin
          if (!rd_q.valid) begin
            state_d = B_RESP;
            if (is_lookup) begin
              res_d.status = lpht_pkg::ST_MISS;
            end else begin
              we       = 1'b1;
              wa       = cur_q;
              wd.valid = 1'b1;
              wd.key   = cmd_q.key_chars[KEY_W-1:0];
              wd.len   = cmd_q.key_len;
              wd.value = val_in_wide[VALUE_BITS-1:0];
              res_d.status     = dup_q ? lpht_pkg::ST_DUP : lpht_pkg::ST_OK;
              res_d.slot_index = to_slot(cur_q);
            end
          end else if (is_lookup && match) begin
            state_d           = B_RESP;
            res_d.found       = 1'b1;
            res_d.found_value = val_out_wide[15:0];
            res_d.status      = lpht_pkg::ST_OK;
            res_d.slot_index  = to_slot(cur_q);
          end else if (vis_q == LAST_CNT) begin
            state_d      = B_RESP;
            res_d.status = is_lookup ? lpht_pkg::ST_MISS : lpht_pkg::ST_FULL;
          end else begin
            vis_d = vis_q + CNT_W'(1);
            dup_d = dup_q || match;
          end
        end
      end
      B_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          clr_resp_d  = 1'b0;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      clr_resp_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_resp_q  <= clr_resp_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    nxt_q <= nxt_d;
    cur_q <= cur_d;
    vis_q <= vis_d;
    dup_q <= dup_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[nxt_q];
  end

endmodule

/* src/linear_probe_hash_table_core.sv */
// Top level of the linear-probe hash table: front end, queue and back end.
//
// Open-addressing table of SLOT_COUNT slots mapping keys of up to
// MAX_KEY_BYTES bytes to VALUE_BITS-bit register numbers. Each input item is a
// lookup, insert or clear (tuser), or carries the unused action code, and gives
// exactly one result item. The home slot is the running product of the key
// bytes mod SLOT_COUNT, starting at 1. The front end takes an item and, for a
// lookup or insert, works through the key one 4-bit slice of the modular
// multiply per cycle, high nibble before low nibble of each byte; it then sees
// that the hash is done and hands the item to a two-entry queue. A clear or an
// unused action code skips the hash. The front end takes the next item while
// the back end works. The back end takes the item from the queue, issues the
// first read, examines the slots of the walk in turn (the slot memory's single
// read port is pipelined to one probe per cycle; the empty slot that ends a
// walk is examined too) and moves the result into the output register. The
// slower side sets the rate. A clear sweeps every slot of the memory. After
// reset the same sweep runs, during which s_axis_tready stays low.
module linear_probe_hash_table_core #(
  parameter int SLOT_COUNT    = 347,
  parameter int MAX_KEY_BYTES = 8,
  parameter int VALUE_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // key_chars[63:0], key_length[67:64],
                                     // reg_value[83:68], zero[87:84]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // found_value[15:0], slot_index[24:16],
                                     // zero[31:25]
  output logic [2:0]  m_axis_tuser   // found[0], status[2:1]
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int Q_W   = $bits(lpht_pkg::item_t) + IDX_W;

  logic                front_valid, front_ready;
  lpht_pkg::item_t     front_item;
  logic [IDX_W-1:0]    front_home;
  logic                back_valid, back_ready;
  logic [Q_W-1:0]      back_data;
  lpht_pkg::item_t     back_item;
  logic [IDX_W-1:0]    back_home;
  logic                init_busy;
  lpht_pkg::res_t      res;

  lpht_front #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hold_i         (init_busy),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_action_i    (lpht_pkg::action_e'(s_axis_tuser)),
    .in_key_chars_i (s_axis_tdata[63:0]),
    .in_key_len_i   (s_axis_tdata[67:64]),
    .in_reg_value_i (s_axis_tdata[83:68]),
    .q_valid_o      (front_valid),
    .q_ready_i      (front_ready),
    .q_item_o       (front_item),
    .q_home_o       (front_home)
  );

  lpht_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   ({front_home, front_item}),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_data)
  );

  assign back_item = back_data[$bits(lpht_pkg::item_t)-1:0];
  assign back_home = back_data[Q_W-1 -: IDX_W];

  lpht_back #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (back_valid),
    .q_ready_o   (back_ready),
    .q_item_i    (back_item),
    .q_home_i    (back_home),
    .init_busy_o (init_busy),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.slot_index, res.found_value};
  assign m_axis_tuser = {res.status, res.found};

endmodule

/* tb/tb_linear_probe_hash_table_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the linear-probe hash table core.
module tb_linear_probe_hash_table_core;

  localparam int         SLOTS        = 347;
  localparam int         KEY_BYTES    = 8;
  localparam logic [1:0] ACT_NOP      = 2'd3;  // unused action code, must be a no-op
  localparam int         CYCLE_LIMIT  = 1_500_000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 400;   // clear sweep plus pipeline
  localparam int         RANDOM_ITEMS = 40;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  len;
  } key_t;

  // Shadow copy of the table; predicts one result item per accepted item.
  class lpht_scoreboard;
    bit                  occupied   [SLOTS];
    logic [63:0]         stored_key [SLOTS];
    logic [3:0]          stored_len [SLOTS];
    logic [15:0]         stored_val [SLOTS];
    lpht_pkg::res_t      expected_q [$];
    int                  mismatches;

    function new();
      mismatches = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function void note_item(logic [1:0] act, logic [63:0] chars, logic [3:0] len_in,
                            logic [15:0] value);
      int unsigned    len;
      int unsigned    idx;
      int unsigned    visited;
      logic [63:0]    k;
      bit             hit;
      bit             dup;
      lpht_pkg::res_t r;
      r       = '0;
      len     = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
      k       = (len >= 8) ? chars : chars & ((64'd1 << (len * 8)) - 64'd1);
      // home slot: running product of the bytes, reduced at every step
      idx     = 1;
      for (int i = 0; i < len; i++) idx = (idx * k[i*8 +: 8]) % SLOTS;
      visited = 0;
      hit     = 1'b0;
      dup     = 1'b0;
      if (act == lpht_pkg::ACT_LOOKUP) begin
        r.status = lpht_pkg::ST_MISS;
        while (occupied[idx] && visited < SLOTS && !hit) begin
          if (stored_len[idx] == len && stored_key[idx] == k) begin
            hit           = 1'b1;
            r.found       = 1'b1;
            r.found_value = stored_val[idx];
            r.status      = lpht_pkg::ST_OK;
            r.slot_index  = idx[lpht_pkg::SLOT_OUT_W-1:0];
          end else begin
            idx = (idx + 1) % SLOTS;
            visited++;
          end
        end
      end else if (act == lpht_pkg::ACT_INSERT) begin
        // walk the whole run; an equal key on the way only flags a duplicate
        while (occupied[idx] && visited < SLOTS) begin
          if (stored_len[idx] == len && stored_key[idx] == k) dup = 1'b1;
          idx = (idx + 1) % SLOTS;
          visited++;
        end
        if (visited >= SLOTS) begin
          r.status = lpht_pkg::ST_FULL;
        end else begin
          occupied[idx]   = 1'b1;
          stored_key[idx] = k;
          stored_len[idx] = len[3:0];
          stored_val[idx] = value;
          r.status        = dup ? lpht_pkg::ST_DUP : lpht_pkg::ST_OK;
          r.slot_index    = idx[lpht_pkg::SLOT_OUT_W-1:0];
        end
      end else if (act == lpht_pkg::ACT_CLEAR) begin
        foreach (occupied[i]) occupied[i] = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(lpht_pkg::res_t got);
      lpht_pkg::res_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result item with none outstanding: found %0d value %h %s",
                   $time, got.found, got.found_value,
                   $sformatf("status %0d slot %0d", got.status, got.slot_index));
      end else begin
        want = expected_q.pop_front();
        if (got.found !== want.found || got.found_value !== want.found_value ||
            got.status !== want.status || got.slot_index !== want.slot_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected found %0d value %h status %0d slot %0d, got %0d %h %0d %0d",
                     $time, want.found, want.found_value, want.status, want.slot_index,
                     got.found, got.found_value, got.status, got.slot_index);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata  = '0;  // key_chars[63:0], key_length[67:64], reg_value[83:68]
  logic [1:0]  s_axis_tuser  = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // found_value[15:0], slot_index[24:16]
  logic [2:0]  m_axis_tuser;        // found[0], status[2:1]

  lpht_scoreboard sb = new();
  bit             calm          = 1'b0;  // no idling on either side while set
  bit             stall_request = 1'b0;  // asks the receiver for one long hold-off
  int             cycle_count   = 0;

  linear_probe_hash_table_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(lpht_pkg::res_t'({m_axis_tuser[0], m_axis_tdata[15:0],
                                        m_axis_tuser[2:1], m_axis_tdata[24:16]}));
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  function automatic key_t mk(logic [63:0] chars, logic [3:0] len);
    key_t k;
    k.chars = chars;
    k.len   = len;
    return k;
  endfunction

  // Random key; narrow keys draw from a few letters so home slots collide.
  function automatic key_t rand_key(int unsigned lo, int unsigned hi, bit narrow);
    key_t        k;
    int unsigned r;
    k.chars = {$urandom, $urandom};  // bytes past the length stay as noise
    r       = $urandom_range(99);
    if (r < 4)       k.len = 4'd0;
    else if (r < 10) k.len = 4'($urandom_range(15, 9));
    else             k.len = 4'($urandom_range(hi, lo));
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < k.len) begin
        r = $urandom_range(99);
        if (r < 4)       k.chars[i*8 +: 8] = 8'd0;
        else if (r < 9)  k.chars[i*8 +: 8] = 8'($urandom_range(255, 128));
        else if (narrow) k.chars[i*8 +: 8] = 8'h61 + 8'($urandom_range(3));
        else             k.chars[i*8 +: 8] = 8'($urandom_range(127, 1));
      end
    end
    return k;
  endfunction

  // Same key, fresh noise past the length; saturated lengths may change.
  function automatic key_t redress(key_t k);
    key_t v;
    v.chars = {$urandom, $urandom};
    v.len   = (k.len >= KEY_BYTES) ? 4'($urandom_range(15, KEY_BYTES)) : k.len;
    for (int i = 0; i < KEY_BYTES; i++)
      if (i < v.len) v.chars[i*8 +: 8] = k.chars[i*8 +: 8];
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(logic [1:0] act, key_t k, logic [15:0] value);
    while (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'd0, value, k.len, k.chars};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(act, k.chars, k.len, value);
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    key_t        pool [16];
    key_t        k;
    int unsigned r;
    int unsigned done_items;
    bit          hold_asked;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and corner cases
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'h41, 4'd1), 16'h0000); // empty table
    send_op(lpht_pkg::ACT_INSERT, mk(64'h41, 4'd1), 16'hFFFF);
    // noise past the length
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'hFFFF_FFFF_FFFF_FF41, 4'd1), 16'hFFFF);
    send_op(lpht_pkg::ACT_INSERT, mk(64'h41, 4'd1), 16'h0001); // duplicate
    send_op(lpht_pkg::ACT_INSERT, mk(64'h0, 4'd0), 16'h00E0);  // empty key
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'hDEAD_BEEF_0123_4567, 4'd0), 16'h0);
    send_op(lpht_pkg::ACT_INSERT, mk('1, 4'd15), 16'hA5A5);    // length saturates
    send_op(lpht_pkg::ACT_LOOKUP, mk('1, 4'd8), 16'h0);
    send_op(lpht_pkg::ACT_LOOKUP, mk('1, 4'd7), 16'h0);        // shorter key misses
    send_op(lpht_pkg::ACT_INSERT, mk(64'h62_00_61, 4'd3), 16'h5A5A); // zero byte, home 0
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'hFF62_0061, 4'd3), 16'h0);
    send_op(lpht_pkg::ACT_INSERT, mk(64'h7F7F_7F7F_7F7F_7F7F, 4'd8), 16'h0);
    // home 1, probes on
    send_op(lpht_pkg::ACT_INSERT, mk(64'h0101_0101_0101_0101, 4'd8), 16'h8000);
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'h0101_0101_0101_0101, 4'd8), 16'h0);
    send_op(ACT_NOP, mk('1, 4'd15), 16'hFFFF);
    send_op(lpht_pkg::ACT_CLEAR, mk('1, 4'd15), 16'hFFFF);
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'h41, 4'd1), 16'h0);    // gone after clear
    send_op(lpht_pkg::ACT_LOOKUP, mk(64'h0, 4'd0), 16'h0);

    // random episodes over a small key pool: inserts, duplicates, hits, misses
    foreach (pool[i]) pool[i] = i[0] ? rand_key(1, 3, 1'b1) : rand_key(1, 8, 1'b0);
    done_items = 0;
    hold_asked = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      if ($urandom_range(2) == 0) begin
        send_op(lpht_pkg::ACT_CLEAR, rand_key(0, 8, 1'b0), 16'($urandom));
        done_items++;
      end
      foreach (pool[i])
        if ($urandom_range(1)) pool[i] = i[0] ? rand_key(1, 3, 1'b1) : rand_key(1, 8, 1'b0);
      repeat ($urandom_range(60, 10)) begin
        calm = done_items >= 15 && done_items < 35;
        if (done_items >= 10 && !hold_asked) begin
          hold_asked    = 1'b1;
          stall_request = 1'b1;
        end
        r = $urandom_range(99);
        k = redress(pool[$urandom_range(15)]);
        if (r < 50)      send_op(lpht_pkg::ACT_INSERT, k, 16'($urandom));
        else if (r < 90) send_op(lpht_pkg::ACT_LOOKUP, k, 16'($urandom));
        else if (r < 95) send_op(lpht_pkg::ACT_LOOKUP, rand_key(1, 8, 1'b0), 16'($urandom));
        else if (r < 98) send_op(ACT_NOP, rand_key(0, 8, 1'b0), 16'($urandom));
        else             send_op(lpht_pkg::ACT_CLEAR, k, 16'($urandom));
        done_items++;
      end
      if ($urandom_range(3) == 0) wait_drain();
    end

    // fill every slot, then overflow and a full-table walk
    calm = 1'b0;
    wait_drain();
    send_op(lpht_pkg::ACT_CLEAR, rand_key(0, 8, 1'b0), 16'($urandom));
    k = rand_key(1, 4, 1'b0);
    send_op(lpht_pkg::ACT_INSERT, k, 16'($urandom));
    repeat (SLOTS + 1) send_op(lpht_pkg::ACT_INSERT, rand_key(1, 4, 1'b0), 16'($urandom));
    send_op(lpht_pkg::ACT_INSERT, k, 16'($urandom));
    send_op(lpht_pkg::ACT_LOOKUP, redress(k), 16'($urandom));
    send_op(lpht_pkg::ACT_LOOKUP, rand_key(8, 8, 1'b0), 16'($urandom));
    send_op(lpht_pkg::ACT_CLEAR, rand_key(0, 8, 1'b0), 16'($urandom));
    send_op(lpht_pkg::ACT_LOOKUP, redress(k), 16'($urandom));

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
src/lpht_pkg.sv
src/lpht_front.sv
src/lpht_queue.sv
src/lpht_back.sv
src/linear_probe_hash_table_core.sv
tb/tb_linear_probe_hash_table_core.sv
